// ===== hdl/teb_pkg.sv =====
// shared types, constants and the control program of the terminal byte emitter
package teb_pkg;

	// field widths
	localparam int CMD_BITS   = 3;
	localparam int BYTE_BITS  = 8;
	localparam int NUM_BITS   = 32;
	localparam int COORD_FIELD_BITS = 16;
	localparam int COORD_BITS = 16;

	// coordinates are cut to COORD_BITS, then to the field width, before the increment
	localparam int COORD_KEEP_BITS = (COORD_BITS < COORD_FIELD_BITS) ? COORD_BITS
		: COORD_FIELD_BITS;
	localparam logic [COORD_FIELD_BITS-1:0] COORD_MASK =
		COORD_FIELD_BITS'((64'd1 << COORD_KEEP_BITS) - 64'd1);
	localparam int COORD_SUM_BITS = COORD_FIELD_BITS + 1;

	// binary to bcd converter
	localparam int DIGITS     = 10;
	localparam int DIG_IDX_BITS = $clog2(DIGITS);
	localparam int CNT_BITS   = $clog2(NUM_BITS + 1);

	// control program
	localparam int PC_BITS    = 5;

	// commands
	localparam logic [CMD_BITS-1:0] CMD_PUT_CHAR  = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_WRITE_DEC = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_MOVE      = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR     = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_ERASE     = 3'd4;

	// characters
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_ESC  = 8'h1B;
	localparam logic [7:0] CHAR_LBR  = 8'h5B;
	localparam logic [7:0] CHAR_SEMI = 8'h3B;
	localparam logic [7:0] CHAR_H    = 8'h48;
	localparam logic [7:0] CHAR_J    = 8'h4A;
	localparam logic [7:0] CHAR_K    = 8'h4B;
	localparam logic [7:0] CHAR_2    = 8'h32;
	localparam logic [7:0] CHAR_0    = 8'h30;

	// micro-operations
	localparam logic [2:0] OP_HALT      = 3'd0;
	localparam logic [2:0] OP_JNL       = 3'd1;
	localparam logic [2:0] OP_EMIT      = 3'd2;
	localparam logic [2:0] OP_EMIT_CHAR = 3'd3;
	localparam logic [2:0] OP_LOAD      = 3'd4;
	localparam logic [2:0] OP_SHIFT     = 3'd5;
	localparam logic [2:0] OP_DIGITS    = 3'd6;

	// converter load sources
	localparam logic [1:0] SRC_NUMBER = 2'd0;
	localparam logic [1:0] SRC_ROW    = 2'd1;
	localparam logic [1:0] SRC_COL    = 2'd2;

	// program entry points
	localparam logic [PC_BITS-1:0] ENTRY_PUT   = 5'd0;
	localparam logic [PC_BITS-1:0] PUT_TAIL    = 5'd2;
	localparam logic [PC_BITS-1:0] ENTRY_DEC   = 5'd3;
	localparam logic [PC_BITS-1:0] ENTRY_MOVE  = 5'd6;
	localparam logic [PC_BITS-1:0] ENTRY_CLEAR = 5'd16;
	localparam logic [PC_BITS-1:0] ENTRY_ERASE = 5'd23;

	typedef struct packed {
		logic [CMD_BITS-1:0]         command;
		logic [BYTE_BITS-1:0]        char_value;
		logic [NUM_BITS-1:0]         number;
		logic [COORD_FIELD_BITS-1:0] row;
		logic [COORD_FIELD_BITS-1:0] col;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic                 last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [7:0]         arg;
		logic [1:0]         src;
		logic               last;
		logic               fin;
		logic [PC_BITS-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic       load;
		logic [1:0] src;
		logic       shift;
		logic       next;
	} conv_ctrl_t;

	typedef struct packed {
		logic       shift_last;
		logic [3:0] digit;
		logic       digit_last;
	} conv_stat_t;

	typedef struct packed {
		logic                 valid;
		logic [BYTE_BITS-1:0] data;
		logic                 last;
	} emit_t;

	function automatic ctrl_word_t cw_make(input logic [2:0] op, input logic [7:0] arg,
		input logic [1:0] src, input logic last, input logic fin,
		input logic [PC_BITS-1:0] target);
		ctrl_word_t cw;
		cw.op     = op;
		cw.arg    = arg;
		cw.src    = src;
		cw.last   = last;
		cw.fin    = fin;
		cw.target = target;
		return cw;
	endfunction

	// control store
	function automatic ctrl_word_t ucode(input logic [PC_BITS-1:0] pc);
		ctrl_word_t cw;
		cw = cw_make(OP_HALT, 8'h00, SRC_NUMBER, 1'b0, 1'b1, '0);
		case (pc)
			// put char
			5'd0:  cw = cw_make(OP_JNL,       8'h00,     SRC_NUMBER, 1'b0, 1'b0, PUT_TAIL);
			5'd1:  cw = cw_make(OP_EMIT,      CHAR_CR,   SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd2:  cw = cw_make(OP_EMIT_CHAR, 8'h00,     SRC_NUMBER, 1'b1, 1'b1, '0);
			// write decimal
			5'd3:  cw = cw_make(OP_LOAD,      8'h00,     SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd4:  cw = cw_make(OP_SHIFT,     8'h00,     SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd5:  cw = cw_make(OP_DIGITS,    8'h00,     SRC_NUMBER, 1'b1, 1'b1, '0);
			// move cursor
			5'd6:  cw = cw_make(OP_EMIT,      CHAR_ESC,  SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd7:  cw = cw_make(OP_EMIT,      CHAR_LBR,  SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd8:  cw = cw_make(OP_LOAD,      8'h00,     SRC_ROW,    1'b0, 1'b0, '0);
			5'd9:  cw = cw_make(OP_SHIFT,     8'h00,     SRC_ROW,    1'b0, 1'b0, '0);
			5'd10: cw = cw_make(OP_DIGITS,    8'h00,     SRC_ROW,    1'b0, 1'b0, '0);
			5'd11: cw = cw_make(OP_EMIT,      CHAR_SEMI, SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd12: cw = cw_make(OP_LOAD,      8'h00,     SRC_COL,    1'b0, 1'b0, '0);
			5'd13: cw = cw_make(OP_SHIFT,     8'h00,     SRC_COL,    1'b0, 1'b0, '0);
			5'd14: cw = cw_make(OP_DIGITS,    8'h00,     SRC_COL,    1'b0, 1'b0, '0);
			5'd15: cw = cw_make(OP_EMIT,      CHAR_H,    SRC_NUMBER, 1'b1, 1'b1, '0);
			// clear screen
			5'd16: cw = cw_make(OP_EMIT,      CHAR_ESC,  SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd17: cw = cw_make(OP_EMIT,      CHAR_LBR,  SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd18: cw = cw_make(OP_EMIT,      CHAR_2,    SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd19: cw = cw_make(OP_EMIT,      CHAR_J,    SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd20: cw = cw_make(OP_EMIT,      CHAR_ESC,  SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd21: cw = cw_make(OP_EMIT,      CHAR_LBR,  SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd22: cw = cw_make(OP_EMIT,      CHAR_H,    SRC_NUMBER, 1'b1, 1'b1, '0);
			// erase line
			5'd23: cw = cw_make(OP_EMIT,      CHAR_ESC,  SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd24: cw = cw_make(OP_EMIT,      CHAR_LBR,  SRC_NUMBER, 1'b0, 1'b0, '0);
			5'd25: cw = cw_make(OP_EMIT,      CHAR_K,    SRC_NUMBER, 1'b1, 1'b1, '0);
			default: cw = cw_make(OP_HALT, 8'h00, SRC_NUMBER, 1'b0, 1'b1, '0);
		endcase
		return cw;
	endfunction

	function automatic logic [PC_BITS-1:0] entry_of(input logic [CMD_BITS-1:0] cmd);
		logic [PC_BITS-1:0] pc;
		case (cmd)
			CMD_PUT_CHAR:  pc = ENTRY_PUT;
			CMD_WRITE_DEC: pc = ENTRY_DEC;
			CMD_MOVE:      pc = ENTRY_MOVE;
			CMD_CLEAR:     pc = ENTRY_CLEAR;
			CMD_ERASE:     pc = ENTRY_ERASE;
			default:       pc = ENTRY_PUT;
		endcase
		return pc;
	endfunction

endpackage

// ===== hdl/terminal_byte_emitter.sv =====
// top level: command capture, control sequencer, decimal converter, transmit register
// after a command transfer the sequencer runs the command's steps from its entry point; the
// first byte comes from the first step for move, clear and erase, after the line feed test
// for put char and after the 32 conversion shifts for write decimal; then one byte per emit
// step while tx does not stall; move cursor runs two 17-shift conversions and up to 14 bytes;
// the input stalls while the sequencer runs; a disabled port or unknown command is dropped
// reset: asynchronous, clears the port enable, the sequencer and the transmit valid
module terminal_byte_emitter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  teb_pkg::in_item_t                   cmd,
	output logic                                tx_valid,
	input  logic                                tx_stall,
	output teb_pkg::out_item_t                  tx,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data
);
	import teb_pkg::*;

	logic        port_enabled_q;
	in_item_t    item_q;
	logic        tx_valid_q;
	out_item_t   tx_q;
	logic        busy;
	logic        accept;
	logic        start;
	logic        out_free;
	conv_ctrl_t  ctrl;
	conv_stat_t  stat;
	emit_t       emit;

	assign cmd_stall = busy;
	assign cfg_ready = 1'b1;
	assign accept    = cmd_valid & ~busy;
	assign start     = accept & port_enabled_q &
		((cmd.command == CMD_PUT_CHAR) || (cmd.command == CMD_WRITE_DEC) ||
		 (cmd.command == CMD_MOVE) || (cmd.command == CMD_CLEAR) ||
		 (cmd.command == CMD_ERASE));
	assign out_free  = ~tx_valid_q | ~tx_stall;
	assign tx_valid  = tx_valid_q;
	assign tx        = tx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_enabled_q <= 1'b0;
		end else if (cfg_valid) begin
			port_enabled_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
	end

	// transmit register, refilled in the cycle its byte is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (emit.valid) begin
			tx_valid_q <= 1'b1;
		end else if (!tx_stall) begin
			tx_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			tx_q.out_byte <= emit.data;
			tx_q.last     <= emit.last;
		end
	end

	teb_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.command    (cmd.command),
		.char_value (item_q.char_value),
		.out_free   (out_free),
		.stat       (stat),
		.ctrl       (ctrl),
		.emit       (emit),
		.busy       (busy)
	);

	teb_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.number (item_q.number),
		.row    (item_q.row),
		.col    (item_q.col),
		.stat   (stat)
	);

endmodule

// ===== hdl/teb_conv.sv =====
// binary to decimal converter: shift-and-add-3 conversion, then digit readout
module teb_conv (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  teb_pkg::conv_ctrl_t                    ctrl,
	input  logic [teb_pkg::NUM_BITS-1:0]           number,
	input  logic [teb_pkg::COORD_FIELD_BITS-1:0]   row,
	input  logic [teb_pkg::COORD_FIELD_BITS-1:0]   col,
	output teb_pkg::conv_stat_t                    stat
);
	import teb_pkg::*;

	logic [NUM_BITS-1:0]          bin_q;
	logic [DIGITS-1:0][3:0]       bcd_q;
	logic [DIGITS-1:0][3:0]       adj;
	logic [DIGITS*4-1:0]          adj_flat;
	logic [DIGITS*4-1:0]          shifted;
	logic [CNT_BITS-1:0]          cnt_q;
	logic [DIG_IDX_BITS-1:0]      idx_q;
	logic                         fresh_q;
	logic [DIG_IDX_BITS-1:0]      msd;
	logic [DIG_IDX_BITS-1:0]      idx;
	logic [COORD_FIELD_BITS-1:0]  coord_src;
	logic [COORD_SUM_BITS-1:0]    coord_inc;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	assign adj_flat = adj;
	assign shifted  = {adj_flat[DIGITS*4-2:0], bin_q[NUM_BITS-1]};

	// highest nonzero digit, digit zero when the value is zero
	always_comb begin
		msd = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) begin
				msd = DIG_IDX_BITS'(i);
			end
		end
	end

	assign idx = fresh_q ? msd : idx_q;

	assign coord_src = (ctrl.src == SRC_ROW) ? row : col;
	assign coord_inc = {1'b0, coord_src & COORD_MASK} + COORD_SUM_BITS'(1);

	assign stat.shift_last = (cnt_q == CNT_BITS'(1));
	assign stat.digit      = bcd_q[idx];
	assign stat.digit_last = (idx == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			idx_q   <= '0;
			fresh_q <= 1'b0;
		end else if (ctrl.load) begin
			cnt_q   <= (ctrl.src == SRC_NUMBER) ? CNT_BITS'(NUM_BITS) : CNT_BITS'(COORD_SUM_BITS);
			fresh_q <= 1'b1;
		end else if (ctrl.shift) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end else if (ctrl.next) begin
			idx_q   <= idx - DIG_IDX_BITS'(1);
			fresh_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bcd_q <= '0;
			if (ctrl.src == SRC_NUMBER) begin
				bin_q <= number;
			end else begin
				bin_q <= {coord_inc, {(NUM_BITS-COORD_SUM_BITS){1'b0}}};
			end
		end else if (ctrl.shift) begin
			bcd_q <= shifted;
			bin_q <= {bin_q[NUM_BITS-2:0], 1'b0};
		end
	end

endmodule

// ===== hdl/teb_sequencer.sv =====
// step counter and control store that drive the emit path and the converter
module teb_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [teb_pkg::CMD_BITS-1:0]      command,
	input  logic [teb_pkg::BYTE_BITS-1:0]     char_value,
	input  logic                              out_free,
	input  teb_pkg::conv_stat_t               stat,
	output teb_pkg::conv_ctrl_t               ctrl,
	output teb_pkg::emit_t                    emit,
	output logic                              busy
);
	import teb_pkg::*;

	logic [PC_BITS-1:0] pc_q;
	logic               busy_q;
	ctrl_word_t         cw;
	logic               advance;
	logic               jump;
	logic               halt;

	assign cw   = ucode(pc_q);
	assign busy = busy_q;

	always_comb begin
		advance    = 1'b0;
		jump       = 1'b0;
		halt       = 1'b0;
		ctrl.load  = 1'b0;
		ctrl.src   = cw.src;
		ctrl.shift = 1'b0;
		ctrl.next  = 1'b0;
		emit.valid = 1'b0;
		emit.data  = cw.arg;
		emit.last  = cw.last;
		if (busy_q) begin
			case (cw.op)
				OP_JNL: begin
					advance = 1'b1;
					jump    = (char_value != CHAR_LF);
				end
				OP_EMIT: begin
					emit.valid = out_free;
					advance    = out_free;
				end
				OP_EMIT_CHAR: begin
					emit.valid = out_free;
					emit.data  = char_value;
					advance    = out_free;
				end
				OP_LOAD: begin
					ctrl.load = 1'b1;
					advance   = 1'b1;
				end
				OP_SHIFT: begin
					ctrl.shift = 1'b1;
					advance    = stat.shift_last;
				end
				OP_DIGITS: begin
					emit.valid = out_free;
					emit.data  = CHAR_0 | {4'd0, stat.digit};
					emit.last  = cw.last & stat.digit_last;
					ctrl.next  = out_free;
					advance    = out_free & stat.digit_last;
				end
				default: begin
					halt = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= entry_of(command);
		end else if (busy_q) begin
			if (halt) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				if (cw.fin) begin
					busy_q <= 1'b0;
				end else if (jump) begin
					pc_q <= cw.target;
				end else begin
					pc_q <= pc_q + PC_BITS'(1);
				end
			end
		end
	end

endmodule

// ===== hdl/teb_checker.sv =====
// port-level checks for the terminal byte emitter, bound to the top level
module teb_port_props (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic                cmd_stall,
	input  teb_pkg::in_item_t   cmd,
	input  logic                tx_valid,
	input  logic                tx_stall,
	input  teb_pkg::out_item_t  tx,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic                cfg_data
);
	import teb_pkg::*;

	logic en_q;
	logic cmd_xfer;
	logic cmd_known;

	// mirror of the enable register from the write transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			en_q <= cfg_data;
		end
	end

	assign cmd_xfer  = cmd_valid & ~cmd_stall;
	assign cmd_known = (cmd.command == CMD_PUT_CHAR) || (cmd.command == CMD_WRITE_DEC) ||
		(cmd.command == CMD_MOVE) || (cmd.command == CMD_CLEAR) ||
		(cmd.command == CMD_ERASE);

	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_stall |=> tx_valid && $stable(tx))
		else $error("stalled tx byte changed");

	a_unknown_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && !cmd_known |=> !cmd_stall)
		else $error("unknown command occupied the block");

	a_known_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && cmd_known && en_q |=> cmd_stall)
		else $error("command transfer did not start the sequencer");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!en_q && !cmd_stall && !tx_valid |=> !tx_valid)
		else $error("byte emitted while port disabled");

endmodule

bind terminal_byte_emitter teb_port_props u_teb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.tx_valid  (tx_valid),
	.tx_stall  (tx_stall),
	.tx        (tx),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_data  (cfg_data)
);
